@@ rtl/core/priority_request_scheduler_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the priority request scheduler
// Short forms for clocked implication checks with reset disable.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_REQUEST_SCHEDULER_TOP_MACROS_SVH
`define PRIORITY_REQUEST_SCHEDULER_TOP_MACROS_SVH

// same-cycle implication
`define PRS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("scheduler check failed");

// next-cycle implication
`define PRS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("scheduler check failed");

`endif

@@ rtl/core/prs_pkg.sv @@
// ----------------------------------------------------------------------------
// prs_pkg
// Types, codes and defaults shared by the priority request scheduler.
// ----------------------------------------------------------------------------
package prs_pkg;

    localparam int CLASSES_DEF = 4;
    localparam int SLOTS_DEF   = 64;
    localparam int OWNERS_DEF  = 16;

    localparam logic [6:0]  CAP_RESET   = 7'd64;
    localparam logic [15:0] FAIR_RESET  = 16'd8;
    localparam logic [1:0]  MAINT_RESET = 2'd3;

    // config register indexes
    localparam logic [1:0] CFG_CAPACITY = 2'd0;
    localparam logic [1:0] CFG_FAIRNESS = 2'd1;
    localparam logic [1:0] CFG_MAINT    = 2'd2;

    // word modes
    localparam logic [1:0] MODE_ENQ     = 2'd0;
    localparam logic [1:0] MODE_POP     = 2'd1;
    localparam logic [1:0] MODE_SET_GEN = 2'd2;

    // result status codes
    localparam logic [2:0] ST_QUEUED    = 3'd0;
    localparam logic [2:0] ST_COALESCED = 3'd1;
    localparam logic [2:0] ST_EVICTED   = 3'd2;
    localparam logic [2:0] ST_REJECTED  = 3'd3;
    localparam logic [2:0] ST_POPPED    = 3'd4;
    localparam logic [2:0] ST_STALE     = 3'd5;
    localparam logic [2:0] ST_EMPTY     = 3'd6;
    localparam logic [2:0] ST_GEN_SET   = 3'd7;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  priority_req;
        logic [3:0]  request_kind;
        logic [31:0] request_id;
        logic [63:0] generation;
        logic [7:0]  owner;
        logic [31:0] coalescing_key;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  item_kind;
        logic [31:0] item_id;
        logic [63:0] item_generation;
        logic [7:0]  item_owner;
        logic [1:0]  item_class;
        logic [6:0]  queue_depth;
    } t_out;

    // one stored request
    typedef struct packed {
        logic [31:0] id;
        logic [63:0] gen;
        logic [31:0] key;
        logic [7:0]  owner;
        logic [3:0]  kind;
    } t_slot;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CMP,
        S_PLACE,
        S_EVICT,
        S_POP_RD,
        S_POP_GEN,
        S_DONE
    } t_state;

endpackage

@@ rtl/core/priority_request_scheduler_top.sv @@
// ----------------------------------------------------------------------------
// priority_request_scheduler_top
// Multi-class request queue with coalescing, eviction and a fairness guard.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid/o_in_ready, i_in_data) takes one command word:
//   enqueue, pop next, or set owner generation. Each word yields exactly one
//   result word on the output channel (o_out_valid/i_out_ready, o_out_data).
//   Config writes (i_cfg_we, i_cfg_idx, i_cfg_data) apply at once; issue
//   them only while the block is idle.
//   A pop passes its read and generation states; set-generation and mode 3
//   go straight to the result. An enqueue without key is placed directly,
//   with an eviction step when full. A keyed enqueue scans stored requests
//   through the single read port of the slot memory, one class after
//   another, and places the request on a miss; a hit ends the scan early.
//   One word is in work at a time; the next is taken once the result sits
//   in the output register.
//   Reset clears class heads, counts, fairness counter and owner valid bits;
//   no clearing pass is needed. A stalled receiver holds the output register
//   and the block waits in its final state with the next result.
// ----------------------------------------------------------------------------
module priority_request_scheduler_top #(
    parameter int CLASSES = prs_pkg::CLASSES_DEF,
    parameter int SLOTS   = prs_pkg::SLOTS_DEF,
    parameter int OWNERS  = prs_pkg::OWNERS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  prs_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output prs_pkg::t_out o_out_data,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [15:0]   i_cfg_data
);

    localparam int CW    = $clog2(CLASSES);
    localparam int RW    = $clog2(SLOTS);
    localparam int RW1   = RW + 1;
    localparam int CNTW  = $clog2(SLOTS + 1);
    localparam int DEPTH = CLASSES * SLOTS;
    localparam int AW    = $clog2(DEPTH);
    localparam int OW    = (OWNERS > 1) ? $clog2(OWNERS) : 1;
    localparam int SUMW  = CNTW + CW;

    prs_pkg::t_state r_state, n_state;
    prs_pkg::t_in    r_in, n_in;
    prs_pkg::t_out   r_res, n_res;
    prs_pkg::t_out   r_out, n_out;
    logic            r_out_valid, n_out_valid;

    logic [CW-1:0]   r_cls_in, n_cls_in;
    logic [CW-1:0]   r_c, n_c;
    logic [CNTW-1:0] r_i, n_i;
    logic [CW-1:0]   r_sel_cls, n_sel_cls;
    logic [AW-1:0]   r_scan_addr, n_scan_addr;

    logic [RW-1:0]   r_heads [CLASSES];
    logic [RW-1:0]   n_heads [CLASSES];
    logic [CNTW-1:0] r_counts [CLASSES];
    logic [CNTW-1:0] n_counts [CLASSES];
    logic [CNTW-1:0] r_total, n_total;
    logic [15:0]     r_since, n_since;

    logic [6:0]      r_cap;
    logic [15:0]     r_fair;
    logic [1:0]      r_maint;

    prs_pkg::t_slot  r_slot_mem [DEPTH];
    prs_pkg::t_slot  r_rd_data;
    logic [AW-1:0]   s_rd_addr;
    logic            s_wr_en;
    logic [AW-1:0]   s_wr_addr;
    prs_pkg::t_slot  s_wr_data;

    logic [63:0]     r_og_mem [OWNERS];
    logic            r_og_valid [OWNERS];
    logic [63:0]     r_og_rd;
    logic            r_og_rd_valid;
    logic [OW-1:0]   s_og_addr;

    logic            s_in_acc;
    logic            s_out_free;
    logic [CNTW-1:0] s_cap;
    logic [15:0]     s_interval;
    logic [CW-1:0]   s_maint;
    logic            s_pop_none;
    logic [CW-1:0]   s_pop_cls;
    logic            s_full;
    logic            s_victim_ok;
    logic [CW-1:0]   s_victim;
    logic            s_scan_hit;
    logic [63:0]     s_cur_gen;
    logic [SUMW-1:0] s_count_sum;
    prs_pkg::t_slot  s_new_slot;

    function automatic logic [AW-1:0] f_slot(input logic [CW-1:0] cls,
                                             input logic [RW1-1:0] sum);
        logic [RW1-1:0] ring;
        ring = (sum >= RW1'(SLOTS)) ? sum - RW1'(SLOTS) : sum;
        return AW'(cls) * AW'(SLOTS) + AW'(ring);
    endfunction

    function automatic logic [CW-1:0] f_clamp_cls(input logic [7:0] v);
        return (32'(v) > 32'(CLASSES - 1)) ? CW'(CLASSES - 1) : CW'(v);
    endfunction

    function automatic logic [OW-1:0] f_clamp_owner(input logic [7:0] v);
        return (32'(v) > 32'(OWNERS - 1)) ? OW'(OWNERS - 1) : OW'(v);
    endfunction

    assign o_in_ready  = (r_state == prs_pkg::S_IDLE);
    assign s_in_acc    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign s_out_free  = !r_out_valid || i_out_ready;

    // effective config values
    always_comb begin
        if (r_cap == 7'd0) begin
            s_cap = CNTW'(1);
        end else if (32'(r_cap) > 32'(SLOTS)) begin
            s_cap = CNTW'(SLOTS);
        end else begin
            s_cap = CNTW'(r_cap);
        end
        s_interval = (r_fair == 16'd0) ? 16'd1 : r_fair;
        s_maint    = (32'(r_maint) > 32'(CLASSES - 1)) ? CW'(CLASSES - 1) : CW'(r_maint);
    end

    // pop class choice and eviction victim
    always_comb begin
        s_pop_none  = 1'b1;
        s_pop_cls   = '0;
        s_victim_ok = 1'b0;
        s_victim    = '0;
        s_count_sum = '0;
        for (int c = CLASSES - 1; c >= 0; c--) begin
            if (r_counts[c] != '0) begin
                s_pop_none = 1'b0;
                s_pop_cls  = CW'(c);
            end
        end
        if (r_since >= s_interval && r_counts[s_maint] != '0) begin
            s_pop_cls = s_maint;
        end
        for (int v = 0; v < CLASSES; v++) begin
            if (CW'(v) > r_cls_in && r_counts[v] != '0) begin
                s_victim_ok = 1'b1;
                s_victim    = CW'(v);
            end
            s_count_sum = s_count_sum + SUMW'(r_counts[v]);
        end
        s_full     = (r_total >= s_cap);
        s_scan_hit = (r_rd_data.key == r_in.coalescing_key);
        s_cur_gen  = r_og_rd_valid ? r_og_rd : 64'd0;
        s_new_slot = '{id: r_in.request_id, gen: r_in.generation,
                       key: r_in.coalescing_key, owner: r_in.owner,
                       kind: r_in.request_kind};
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            prs_pkg::S_IDLE: begin
                if (s_in_acc) begin
                    case (i_in_data.mode)
                        prs_pkg::MODE_ENQ: begin
                            n_state = (i_in_data.coalescing_key != '0) ?
                                      prs_pkg::S_SCAN : prs_pkg::S_PLACE;
                        end
                        prs_pkg::MODE_POP: begin
                            n_state = s_pop_none ? prs_pkg::S_DONE : prs_pkg::S_POP_RD;
                        end
                        default: n_state = prs_pkg::S_DONE;
                    endcase
                end
            end
            prs_pkg::S_SCAN: begin
                if (r_i < r_counts[r_c]) begin
                    n_state = prs_pkg::S_CMP;
                end else if (r_c == CW'(CLASSES - 1)) begin
                    n_state = prs_pkg::S_PLACE;
                end
            end
            prs_pkg::S_CMP:     n_state = s_scan_hit ? prs_pkg::S_DONE : prs_pkg::S_SCAN;
            prs_pkg::S_PLACE: begin
                n_state = (s_full && s_victim_ok) ? prs_pkg::S_EVICT : prs_pkg::S_DONE;
            end
            prs_pkg::S_EVICT:   n_state = prs_pkg::S_DONE;
            prs_pkg::S_POP_RD:  n_state = prs_pkg::S_POP_GEN;
            prs_pkg::S_POP_GEN: n_state = prs_pkg::S_DONE;
            prs_pkg::S_DONE:    n_state = s_out_free ? prs_pkg::S_IDLE : prs_pkg::S_DONE;
            default:            n_state = prs_pkg::S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_in        = r_in;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        n_cls_in    = r_cls_in;
        n_c         = r_c;
        n_i         = r_i;
        n_sel_cls   = r_sel_cls;
        n_scan_addr = r_scan_addr;
        n_heads     = r_heads;
        n_counts    = r_counts;
        n_total     = r_total;
        n_since     = r_since;
        s_rd_addr   = '0;
        s_wr_en     = 1'b0;
        s_wr_addr   = '0;
        s_wr_data   = s_new_slot;
        s_og_addr   = f_clamp_owner(r_rd_data.owner);

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            prs_pkg::S_IDLE: begin
                if (s_in_acc) begin
                    n_in     = i_in_data;
                    n_cls_in = f_clamp_cls(i_in_data.priority_req);
                    n_c      = '0;
                    n_i      = '0;
                    n_res    = '0;
                    case (i_in_data.mode)
                        prs_pkg::MODE_ENQ: n_res.status = prs_pkg::ST_QUEUED;
                        prs_pkg::MODE_POP: begin
                            if (s_pop_none) begin
                                n_res.status = prs_pkg::ST_EMPTY;
                            end else begin
                                s_rd_addr = f_slot(s_pop_cls, RW1'(r_heads[s_pop_cls]));
                                n_heads[s_pop_cls] =
                                    (32'(r_heads[s_pop_cls]) == 32'(SLOTS - 1)) ? '0 :
                                    r_heads[s_pop_cls] + RW'(1);
                                n_counts[s_pop_cls] = r_counts[s_pop_cls] - CNTW'(1);
                                n_total   = r_total - CNTW'(1);
                                n_sel_cls = s_pop_cls;
                                if (s_pop_cls == s_maint) begin
                                    n_since = '0;
                                end else if (r_since != 16'hFFFF) begin
                                    n_since = r_since + 16'd1;
                                end
                            end
                        end
                        prs_pkg::MODE_SET_GEN: n_res.status = prs_pkg::ST_GEN_SET;
                        default:               n_res.status = prs_pkg::ST_REJECTED;
                    endcase
                end
            end
            prs_pkg::S_SCAN: begin
                if (r_i < r_counts[r_c]) begin
                    s_rd_addr   = f_slot(r_c, RW1'(r_heads[r_c]) + RW1'(r_i));
                    n_scan_addr = s_rd_addr;
                end else if (r_c != CW'(CLASSES - 1)) begin
                    n_c = r_c + CW'(1);
                    n_i = '0;
                end
            end
            prs_pkg::S_CMP: begin
                if (s_scan_hit) begin
                    s_wr_en      = 1'b1;
                    s_wr_addr    = r_scan_addr;
                    n_res.status = prs_pkg::ST_COALESCED;
                end else begin
                    n_i = r_i + CNTW'(1);
                end
            end
            prs_pkg::S_PLACE: begin
                if (s_full && s_victim_ok) begin
                    s_rd_addr = f_slot(s_victim, RW1'(r_heads[s_victim]) +
                                       RW1'(r_counts[s_victim] - CNTW'(1)));
                    n_counts[s_victim] = r_counts[s_victim] - CNTW'(1);
                    n_total   = r_total - CNTW'(1);
                    n_sel_cls = s_victim;
                end else if (s_full) begin
                    n_res.status = prs_pkg::ST_REJECTED;
                end else begin
                    s_wr_en   = 1'b1;
                    s_wr_addr = f_slot(r_cls_in, RW1'(r_heads[r_cls_in]) +
                                       RW1'(r_counts[r_cls_in]));
                    n_counts[r_cls_in] = r_counts[r_cls_in] + CNTW'(1);
                    n_total      = r_total + CNTW'(1);
                    n_res.status = prs_pkg::ST_QUEUED;
                end
            end
            prs_pkg::S_EVICT: begin
                // victim class differs from the incoming one, so no overlap
                n_res.status          = prs_pkg::ST_EVICTED;
                n_res.item_kind       = r_rd_data.kind;
                n_res.item_id         = r_rd_data.id;
                n_res.item_generation = r_rd_data.gen;
                n_res.item_owner      = r_rd_data.owner;
                n_res.item_class      = 2'(r_sel_cls);
                s_wr_en   = 1'b1;
                s_wr_addr = f_slot(r_cls_in, RW1'(r_heads[r_cls_in]) +
                                   RW1'(r_counts[r_cls_in]));
                n_counts[r_cls_in] = r_counts[r_cls_in] + CNTW'(1);
                n_total = r_total + CNTW'(1);
            end
            prs_pkg::S_POP_RD: begin
                n_res.item_kind       = r_rd_data.kind;
                n_res.item_id         = r_rd_data.id;
                n_res.item_generation = r_rd_data.gen;
                n_res.item_owner      = r_rd_data.owner;
                n_res.item_class      = 2'(r_sel_cls);
            end
            prs_pkg::S_POP_GEN: begin
                n_res.status = (r_res.item_generation != 64'd0 &&
                                r_res.item_generation != s_cur_gen) ?
                               prs_pkg::ST_STALE : prs_pkg::ST_POPPED;
            end
            prs_pkg::S_DONE: begin
                if (s_out_free) begin
                    n_out             = r_res;
                    n_out.queue_depth = 7'(r_total);
                    n_out_valid       = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // slot memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (s_wr_en) begin
            r_slot_mem[s_wr_addr] <= s_wr_data;
        end
        r_rd_data <= r_slot_mem[s_rd_addr];
    end

    // owner generation memory
    always_ff @(posedge i_clk) begin
        if (s_in_acc && i_in_data.mode == prs_pkg::MODE_SET_GEN) begin
            r_og_mem[f_clamp_owner(i_in_data.owner)] <= i_in_data.generation;
        end
        r_og_rd <= r_og_mem[s_og_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < OWNERS; k++) begin
                r_og_valid[k] <= 1'b0;
            end
            r_og_rd_valid <= 1'b0;
        end else begin
            if (s_in_acc && i_in_data.mode == prs_pkg::MODE_SET_GEN) begin
                r_og_valid[f_clamp_owner(i_in_data.owner)] <= 1'b1;
            end
            r_og_rd_valid <= r_og_valid[s_og_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= prs_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_total     <= '0;
            r_since     <= '0;
            r_cap       <= prs_pkg::CAP_RESET;
            r_fair      <= prs_pkg::FAIR_RESET;
            r_maint     <= prs_pkg::MAINT_RESET;
            for (int k = 0; k < CLASSES; k++) begin
                r_heads[k]  <= '0;
                r_counts[k] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_total     <= n_total;
            r_since     <= n_since;
            r_heads     <= n_heads;
            r_counts    <= n_counts;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    prs_pkg::CFG_CAPACITY: r_cap   <= i_cfg_data[6:0];
                    prs_pkg::CFG_FAIRNESS: r_fair  <= i_cfg_data;
                    prs_pkg::CFG_MAINT:    r_maint <= i_cfg_data[1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_in        <= n_in;
        r_res       <= n_res;
        r_out       <= n_out;
        r_cls_in    <= n_cls_in;
        r_c         <= n_c;
        r_i         <= n_i;
        r_sel_cls   <= n_sel_cls;
        r_scan_addr <= n_scan_addr;
    end

    `include "priority_request_scheduler_top_macros.svh"

    `PRS_ASSERT_NEXT(a_busy_after_accept, s_in_acc, r_state != prs_pkg::S_IDLE)
    `PRS_ASSERT_NOW(a_total_matches_counts, 1'b1, s_count_sum == SUMW'(r_total))
    `PRS_ASSERT_NOW(a_total_bounded, 1'b1, 32'(r_total) <= 32'(SLOTS))
    `PRS_ASSERT_NEXT(a_done_loads_out, r_state == prs_pkg::S_DONE && s_out_free,
                     r_out_valid && r_state == prs_pkg::S_IDLE)

endmodule
